>>> src/assert_macros.svh
// Assertion macros shared by the periodic force generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, clocked on clk and held off while rst_n is low
`define PFWG_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, clocked on clk and held off while rst_n is low
`define PFWG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PFWG_ASSERT_IMPL(label, ante, cons, msg)
`define PFWG_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> src/pfwg_pkg.sv
// Types, constants and the sine table builder of the periodic force generator.
package pfwg_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_WAVEFORM_SELECT = 3'd0,
    CFG_PHASE_STEP      = 3'd1,
    CFG_PHASE_START     = 3'd2,
    CFG_OFFSET_VALUE    = 3'd3,
    CFG_MAX_STEP        = 3'd4
  } cfg_index_t;

  // Waveform codes
  typedef enum logic [2:0] {
    WAVE_SQUARE   = 3'd0,
    WAVE_TRIANGLE = 3'd1,
    WAVE_SINE     = 3'd2,
    WAVE_SAW_UP   = 3'd3,
    WAVE_SAW_DOWN = 3'd4
  } wave_sel_t;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned LEVEL_W    = 15;
  localparam int unsigned FORCE_W    = 16;
  localparam int unsigned WAVE_W     = 18;  // signed Q2.16 wave sample
  localparam int unsigned ROM_W      = 17;  // unsigned Q1.16, up to 1.0

  // pi/2 in Q2.30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Taylor series for sin(x), x in Q2.30, result rounded to Q1.16.
  // Only ever evaluated at elaboration to fill the quarter-wave table.
  function automatic logic [ROM_W-1:0] sine_q16(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        m;
    logic signed [63:0] s;
    logic [63:0]        v;
    x2 = (x * x) >> 30;
    m  = x;
    s  = $signed(x);
    m  = ((m * x2) >> 30) / 64'd6;
    s  = s - $signed(m);
    m  = ((m * x2) >> 30) / 64'd20;
    s  = s + $signed(m);
    m  = ((m * x2) >> 30) / 64'd42;
    s  = s - $signed(m);
    m  = ((m * x2) >> 30) / 64'd72;
    s  = s + $signed(m);
    m  = ((m * x2) >> 30) / 64'd110;
    s  = s - $signed(m);
    m  = ((m * x2) >> 30) / 64'd156;
    s  = s + $signed(m);
    m  = ((m * x2) >> 30) / 64'd210;
    s  = s - $signed(m);
    if (s < 0) begin
      s = '0;
    end
    v = ($unsigned(s) + 64'd8192) >> 14;
    if (v > 64'd65536) begin
      v = 64'd65536;
    end
    return v[ROM_W-1:0];
  endfunction

endpackage

>>> src/periodic_force_waveform_generator_core.sv
// Periodic force waveform generator: phase accumulator, wave shaping, scaling, offset,
// saturation and step-limit muting. Throughput: one beat per cycle while the output is
// not stalled; five register stages (input, table read, multiply, rounding, output)
// each hold while the stage after them is full and stalled.
// rst_n is synchronous, active low: it clears the phase accumulator, the stage
// valid flags and the configuration registers (max_step to all ones, others to zero).
`include "assert_macros.svh"

module periodic_force_waveform_generator_core #(
  parameter int unsigned SINE_TABLE_DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Configuration write port
  input  logic                             cfg_wen,
  input  logic [pfwg_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [pfwg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // Input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [15:0]                      in_tdata,   // [14:0] envelope_level, [15] restart
  // Result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [15:0]                      out_tdata   // [15:0] force_value
);
  import pfwg_pkg::*;

  localparam int unsigned IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned PROD_W = 14 + IDX_W;

  // Configuration registers
  wave_sel_t          wsel_r;
  logic [31:0]        phase_step_r;
  logic [15:0]        phase_start_r;
  logic signed [15:0] offset_r;
  logic [31:0]        max_step_r;

  // Phase accumulator
  logic [31:0] acc_r;
  logic [31:0] acc_nxt;
  logic [31:0] phase_now;

  // Stage valid flags and enables
  logic v1_r, v2_r, v3_r, v4_r, out_v_r;
  logic en1, en2, en3, en4, out_en;
  logic accept;

  // Stage payloads
  logic [15:0]                p1_r;
  logic [LEVEL_W-1:0]         lvl1_r;
  logic [LEVEL_W-1:0]         lvl2_r;
  logic signed [WAVE_W-1:0]   w2_r;
  logic [ROM_W-1:0]           rom2_r;
  logic                       sneg2_r;
  logic signed [31:0]         prod3_r;
  logic [LEVEL_W-1:0]         c4_r;
  logic                       neg4_r;
  logic [FORCE_W-1:0]         force_r;

  // Quarter-wave sine table, built at elaboration
  logic [ROM_W-1:0] sine_rom [SINE_TABLE_DEPTH+1];

  for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
    localparam logic [63:0] ANGLE = (64'(g) * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
    assign sine_rom[g] = sine_q16(ANGLE);
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsel_r        <= WAVE_SQUARE;
      phase_step_r  <= '0;
      phase_start_r <= '0;
      offset_r      <= '0;
      max_step_r    <= '1;
    end else if (cfg_wen) begin
      case (cfg_index_t'(cfg_addr))
        CFG_WAVEFORM_SELECT: begin
          wsel_r <= (cfg_wdata[2:0] > 3'(WAVE_SAW_DOWN)) ? WAVE_SAW_DOWN
                                                         : wave_sel_t'(cfg_wdata[2:0]);
        end
        CFG_PHASE_STEP:   phase_step_r  <= cfg_wdata;
        CFG_PHASE_START:  phase_start_r <= cfg_wdata[15:0];
        CFG_OFFSET_VALUE: offset_r      <= $signed(cfg_wdata[15:0]);
        CFG_MAX_STEP:     max_step_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pipeline flow: a stage moves on when it is empty or the next one moves
  assign out_en    = !out_v_r || out_tready;
  assign en4       = !v4_r || out_en;
  assign en3       = !v3_r || en4;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_tready = rst_n && en1;
  assign accept    = in_tvalid && in_tready;

  // Phase seen by this beat, then advanced by the step
  assign phase_now = in_tdata[15] ? {phase_start_r, 16'h0000} : acc_r;
  assign acc_nxt   = phase_now + phase_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (accept) begin
        acc_r <= acc_nxt;
      end
      if (en1)    v1_r    <= accept;
      if (en2)    v2_r    <= v1_r;
      if (en3)    v3_r    <= v2_r;
      if (en4)    v4_r    <= v3_r;
      if (out_en) out_v_r <= v4_r;
    end
  end

  // Stage 2: table address and non-sine wave shapes
  logic [PROD_W-1:0]  sidx_prod;
  logic [IDX_W-1:0]   sidx_i;
  logic [IDX_W-1:0]   sidx;
  logic signed [19:0] pe;
  logic signed [19:0] p4;
  logic signed [19:0] wave;

  always_comb begin
    sidx_prod = {{IDX_W{1'b0}}, p1_r[13:0]} * PROD_W'(SINE_TABLE_DEPTH);
    sidx_i    = sidx_prod[PROD_W-1:14];
    sidx      = p1_r[14] ? (IDX_W'(SINE_TABLE_DEPTH) - sidx_i) : sidx_i;
    pe        = $signed({4'b0000, p1_r});
    p4        = $signed({2'b00, p1_r, 2'b00});
    case (wsel_r)
      WAVE_SQUARE:   wave = p1_r[15] ? -20'sd65536 : 20'sd65536;
      WAVE_TRIANGLE: begin
        if (p1_r <= 16'd16384) begin
          wave = p4;
        end else if (p1_r <= 16'd49152) begin
          wave = 20'sd131072 - p4;
        end else begin
          wave = p4 - 20'sd262144;
        end
      end
      WAVE_SINE:     wave = '0;
      WAVE_SAW_UP:   wave = pe;
      WAVE_SAW_DOWN: wave = 20'sd65536 - pe;
      default:       wave = 20'sd65536 - pe;
    endcase
  end

  // Stage 3: wave select and envelope scaling
  logic signed [WAVE_W-1:0] sine_w;
  logic signed [WAVE_W-1:0] w3;
  logic signed [33:0]       prod;

  always_comb begin
    sine_w = sneg2_r ? -$signed({1'b0, rom2_r}) : $signed({1'b0, rom2_r});
    w3     = (wsel_r == WAVE_SINE) ? sine_w : w2_r;
    prod   = $signed({1'b0, lvl2_r}) * w3;
  end

  // Stage 4: round magnitude half away from zero
  logic [31:0] mag;
  logic [31:0] rnd;

  always_comb begin
    mag = prod3_r[31] ? $unsigned(-prod3_r) : $unsigned(prod3_r);
    rnd = mag + 32'd32768;
  end

  // Stage 5: offset, saturation and the step limit
  logic signed [17:0] c_s;
  logic signed [17:0] sum;
  logic [FORCE_W-1:0] force_val;

  always_comb begin
    c_s = neg4_r ? -$signed({3'b000, c4_r}) : $signed({3'b000, c4_r});
    sum = $signed({{2{offset_r[15]}}, offset_r}) + c_s;
    if (phase_step_r > max_step_r) begin
      force_val = '0;
    end else if (sum > 18'sd32767) begin
      force_val = 16'h7FFF;
    end else if (sum < -18'sd32768) begin
      force_val = 16'h8000;
    end else begin
      force_val = sum[15:0];
    end
  end

  // Stage payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      p1_r   <= phase_now[31:16];
      lvl1_r <= in_tdata[14:0];
    end
    if (en2 && v1_r) begin
      lvl2_r  <= lvl1_r;
      w2_r    <= wave[WAVE_W-1:0];
      rom2_r  <= sine_rom[sidx];
      sneg2_r <= p1_r[15];
    end
    if (en3 && v2_r) begin
      prod3_r <= prod[31:0];
    end
    if (en4 && v3_r) begin
      c4_r   <= rnd[30:16];
      neg4_r <= prod3_r[31];
    end
    if (out_en && v4_r) begin
      force_r <= force_val;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = force_r;

  // Checks
  `PFWG_ASSERT_NEXT(a_acc_advance, accept && !in_tdata[15],
                    acc_r == $past(acc_r + phase_step_r), "phase did not advance by step")
  `PFWG_ASSERT_NEXT(a_acc_restart, accept && in_tdata[15],
                    acc_r == $past({phase_start_r, 16'h0000} + phase_step_r),
                    "restart did not reload phase")
  `PFWG_ASSERT_IMPL(a_step_limit, out_tvalid && (phase_step_r > max_step_r),
                    out_tdata == '0, "result not zero above step limit")
  `PFWG_ASSERT_IMPL(a_full_when_blocked, rst_n && !in_tready,
                    v1_r && v2_r && v3_r && v4_r && out_v_r,
                    "input blocked while pipeline has room")

endmodule

>>> dv/tb.sv
// Testbench for the periodic force generator: directed and random beats checked against a predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pfwg_pkg::*;

  localparam int SINE_DEPTH   = 256;
  localparam int PIPE_CYCLES  = 8;    // covers the five pipeline stages plus margin
  localparam int RANDOM_BEATS = 500;
  localparam logic [2:0] WAVE_CODE_UNUSED = 3'd7;  // out of range, clamps to saw down

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_wen    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata   = '0;   // [14:0] envelope_level, [15] restart
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [15:0]           out_tdata;         // [15:0] force_value

  // Generator registers as the predictor tracks them
  typedef struct {
    wave_sel_t          wave;
    logic [31:0]        step;
    logic [15:0]        start;
    logic signed [15:0] offset;
    logic [31:0]        max_step;
  } gen_settings_t;

  gen_settings_t settings;
  logic [31:0]   phase_acc;
  int unsigned   quarter_sine [0:SINE_DEPTH];
  logic [15:0]   expected_force [$];
  int            mismatches = 0;
  bit            steady = 1'b0;   // both sides busy every cycle while set

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  periodic_force_waveform_generator_core #(
    .SINE_TABLE_DEPTH(SINE_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // Quarter-wave sine entry in Q1.16, eight-term series in Q2.30
  function automatic int unsigned sine_entry(int idx);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned rounded;
    longint          acc;
    x    = longint'(idx);
    x    = x * HALF_PI_Q30 / SINE_DEPTH;
    x2   = (x * x) >> 30;
    term = x;
    acc  = x;
    for (int k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
      if (k % 2) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    rounded = (acc + 8192) >> 14;
    if (rounded > 65536) rounded = 65536;
    return 32'(rounded);
  endfunction

  // Wave sample in Q2.16 for cycle fraction p
  function automatic longint wave_at(logic [15:0] p);
    longint pl;
    int     idx;
    pl = longint'(p);
    case (settings.wave)
      WAVE_SQUARE:   return p[15] ? -65536 : 65536;
      WAVE_TRIANGLE: begin
        if (pl <= 16384) return 4 * pl;
        if (pl <= 49152) return 131072 - 4 * pl;
        return 4 * pl - 262144;
      end
      WAVE_SINE: begin
        idx = (int'(p[13:0]) * SINE_DEPTH) >> 14;
        if (p[14]) idx = SINE_DEPTH - idx;
        return p[15] ? -longint'(quarter_sine[idx]) : longint'(quarter_sine[idx]);
      end
      WAVE_SAW_UP:   return pl;
      default:       return 65536 - pl;
    endcase
  endfunction

  // Force for one tick; moves the phase on as the block does
  function automatic logic [15:0] next_force(logic [14:0] level, logic restart);
    longint prod;
    longint mag;
    longint c;
    longint f;
    if (restart) phase_acc = {settings.start, 16'h0000};
    f = 0;
    if (settings.step <= settings.max_step) begin
      prod = longint'(level) * wave_at(phase_acc[31:16]);
      mag  = (prod < 0) ? -prod : prod;
      c    = (mag + 32768) >>> 16;
      if (prod < 0) c = -c;
      f = longint'(settings.offset) + c;
      if (f > 32767) f = 32767;
      else if (f < -32768) f = -32768;
    end
    phase_acc = phase_acc + settings.step;
    return f[15:0];
  endfunction

  // Receiver stalls
  always @(posedge clk) out_tready <= steady || ($urandom_range(0, 99) >= 29);

  // Result check against the oldest expected force
  always @(posedge clk) begin : force_check
    logic [15:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_force.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%t: unexpected force beat %0d", $time, $signed(out_tdata));
      end else begin
        want = expected_force.pop_front();
        if (out_tdata !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%t: force_value expected %0d got %0d", $time,
                     $signed(want), $signed(out_tdata));
        end
      end
    end
  end

  task automatic write_reg(cfg_index_t idx, logic [31:0] data);
    cfg_wen   <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_WAVEFORM_SELECT:
        settings.wave = (data[2:0] > WAVE_SAW_DOWN) ? WAVE_SAW_DOWN : wave_sel_t'(data[2:0]);
      CFG_PHASE_STEP:   settings.step     = data;
      CFG_PHASE_START:  settings.start    = data[15:0];
      CFG_OFFSET_VALUE: settings.offset   = data[15:0];
      CFG_MAX_STEP:     settings.max_step = data;
      default: ;
    endcase
  endtask

  // One envelope beat, with random idle cycles ahead of it
  task automatic send_beat(logic [14:0] level, logic restart);
    while (!steady && $urandom_range(0, 99) < 29) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {restart, level};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_force.push_back(next_force(level, restart));
  endtask

  // Hold the sender until every expected force has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_force.size() != 0) @(posedge clk);
    repeat (PIPE_CYCLES) @(posedge clk);
  endtask

  // Registers at reset: square, zero step, so force equals the level
  task automatic test_reset_state();
    send_beat(15'h7FFF, 1'b0);
    send_beat(15'h0000, 1'b1);
    send_beat(15'd12345, 1'b0);
    wait_drained();
  endtask

  // Each wave at the quadrant edges, plus an out-of-range select
  task automatic test_waveforms();
    wave_sel_t w;
    write_reg(CFG_PHASE_STEP, 32'h4000_0000);
    write_reg(CFG_PHASE_START, 32'h0000_C000);
    w = w.first();
    do begin
      write_reg(CFG_WAVEFORM_SELECT, 32'(w));
      send_beat(15'h7FFF, 1'b1);
      send_beat(15'h7FFF, 1'b0);   // wraps through zero
      send_beat(15'd20000, 1'b0);
      wait_drained();
      w = w.next();
    end while (w != w.first());
    write_reg(CFG_WAVEFORM_SELECT, {29'h1FFF_FFFF, WAVE_CODE_UNUSED});
    send_beat(15'h7FFF, 1'b1);
    wait_drained();
  endtask

  // Offset at both rails drives the sum into saturation
  task automatic test_saturation();
    write_reg(CFG_WAVEFORM_SELECT, 32'(WAVE_SQUARE));
    write_reg(CFG_PHASE_STEP, 32'h8000_0000);
    write_reg(CFG_PHASE_START, 32'h0000_0000);
    write_reg(CFG_OFFSET_VALUE, 32'h0000_7FFF);
    send_beat(15'h7FFF, 1'b1);
    send_beat(15'h7FFF, 1'b0);
    wait_drained();
    write_reg(CFG_OFFSET_VALUE, 32'hFFFF_8000);
    send_beat(15'h7FFF, 1'b1);
    send_beat(15'h7FFF, 1'b0);
    wait_drained();
  endtask

  // Step above the limit mutes the output; equal to it does not
  task automatic test_step_limit();
    write_reg(CFG_MAX_STEP, 32'h0FFF_FFFF);
    write_reg(CFG_PHASE_STEP, 32'h1000_0000);
    send_beat(15'h7FFF, 1'b1);
    send_beat(15'h7FFF, 1'b0);
    wait_drained();
    write_reg(CFG_PHASE_STEP, 32'h0FFF_FFFF);
    send_beat(15'h7FFF, 1'b0);
    wait_drained();
    write_reg(CFG_MAX_STEP, 32'hFFFF_FFFF);
  endtask

  // Random settings per phase, random levels and occasional restarts
  task automatic test_random_settings();
    int          sent;
    int          phase;
    int          beats;
    logic [31:0] step;
    logic [31:0] limit;
    logic [15:0] offset;
    logic [14:0] level;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_BEATS) begin
      wait_drained();
      case ($urandom_range(0, 5))
        0:       step = 32'h0000_0000;
        1:       step = 32'hFFFF_FFFF;
        2, 3:    step = $urandom_range(0, 32'h00FF_FFFF);
        default: step = $urandom();
      endcase
      case ($urandom_range(0, 9))
        0:       limit = 32'h0000_0000;
        1:       limit = $urandom();
        2:       limit = step;
        3:       limit = step - 32'd1;
        default: limit = 32'hFFFF_FFFF;
      endcase
      case ($urandom_range(0, 5))
        0:       offset = 16'h7FFF;
        1:       offset = 16'h8000;
        2:       offset = 16'h0000;
        default: offset = 16'($urandom());
      endcase
      write_reg(CFG_WAVEFORM_SELECT, $urandom());
      write_reg(CFG_PHASE_STEP, step);
      write_reg(CFG_PHASE_START, $urandom());
      write_reg(CFG_OFFSET_VALUE, {16'($urandom()), offset});
      write_reg(CFG_MAX_STEP, limit);
      beats  = $urandom_range(20, 60);
      steady = (phase == 3);
      repeat (beats) begin
        case ($urandom_range(0, 9))
          0:       level = 15'h0000;
          1:       level = 15'h7FFF;
          default: level = 15'($urandom_range(0, 32767));
        endcase
        send_beat(level, $urandom_range(0, 99) < 6);
      end
      sent += beats;
      phase++;
    end
    steady = 1'b0;
  endtask

  initial begin
    for (int i = 0; i <= SINE_DEPTH; i++) quarter_sine[i] = sine_entry(i);
    settings = '{wave: WAVE_SQUARE, step: '0, start: '0, offset: '0, max_step: '1};
    phase_acc = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_waveforms();
    test_saturation();
    test_step_limit();
    test_random_settings();
    wait_drained();
    if (mismatches == 0 && expected_force.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/pfwg_pkg.sv
src/periodic_force_waveform_generator_core.sv
dv/tb.sv
